[rtl/hangul_syllable_composer_assert.svh]
// ----------------------------------------------------------------------------
// hangul syllable composer assertion macros
// Property macros shared by the composer's checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HANGUL_SYLLABLE_COMPOSER_ASSERT_SVH
`define HANGUL_SYLLABLE_COMPOSER_ASSERT_SVH

// same-cycle implication
`define HSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, codes and jamo tables of the hangul syllable composer.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // code point ranges and syllable base
    localparam logic [15:0] CONS_FIRST = 16'h3131;
    localparam logic [15:0] CONS_LAST  = 16'h314E;
    localparam logic [15:0] VOW_FIRST  = 16'h314F;
    localparam logic [15:0] VOW_LAST   = 16'h3163;
    localparam logic [15:0] SYL_BASE   = 16'hAC00;
    localparam logic [15:0] INI_STEP   = 16'd588;
    localparam logic [15:0] MED_STEP   = 16'd28;

    // commands
    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_BACK   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // slot cursor positions
    localparam logic [1:0] CUR_INI = 2'd0;
    localparam logic [1:0] CUR_MED = 2'd1;
    localparam logic [1:0] CUR_FIN = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] key_code;
    } item_t;

    typedef struct packed {
        logic        commit_valid;
        logic [15:0] commit_char;
        logic        pass_valid;
        logic [15:0] pass_char;
        logic        erase_committed;
        logic [15:0] preedit_char;
    } result_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] first;
        logic [15:0] second;
    } pair_t;

    function automatic logic is_cons(input logic [15:0] c);
        return (c >= CONS_FIRST) && (c <= CONS_LAST);
    endfunction

    function automatic logic is_vowel(input logic [15:0] c);
        return (c >= VOW_FIRST) && (c <= VOW_LAST);
    endfunction

    // initial index of a consonant, 0 for compounds and non-consonants
    function automatic logic [4:0] init_idx(input logic [15:0] c);
        logic [15:0] d;
        logic [4:0]  r;
        d = c - CONS_FIRST;
        r = 5'd0;
        if (is_cons(c))
        begin
            case (d[4:0])
                5'd0:  r = 5'd0;
                5'd1:  r = 5'd1;
                5'd3:  r = 5'd2;
                5'd6:  r = 5'd3;
                5'd7:  r = 5'd4;
                5'd8:  r = 5'd5;
                5'd16: r = 5'd6;
                5'd17: r = 5'd7;
                5'd18: r = 5'd8;
                5'd20: r = 5'd9;
                5'd21: r = 5'd10;
                5'd22: r = 5'd11;
                5'd23: r = 5'd12;
                5'd24: r = 5'd13;
                5'd25: r = 5'd14;
                5'd26: r = 5'd15;
                5'd27: r = 5'd16;
                5'd28: r = 5'd17;
                5'd29: r = 5'd18;
                default: r = 5'd0;
            endcase
        end
        return r;
    endfunction

    // final index of a consonant, 0 when it cannot close a syllable
    function automatic logic [4:0] fin_idx(input logic [15:0] c);
        logic [15:0] d;
        logic [4:0]  r;
        d = c - CONS_FIRST;
        r = 5'd0;
        if (is_cons(c))
        begin
            case (d[4:0])
                5'd0:  r = 5'd1;
                5'd1:  r = 5'd2;
                5'd2:  r = 5'd3;
                5'd3:  r = 5'd4;
                5'd4:  r = 5'd5;
                5'd5:  r = 5'd6;
                5'd6:  r = 5'd7;
                5'd8:  r = 5'd8;
                5'd9:  r = 5'd9;
                5'd10: r = 5'd10;
                5'd11: r = 5'd11;
                5'd12: r = 5'd12;
                5'd13: r = 5'd13;
                5'd14: r = 5'd14;
                5'd15: r = 5'd15;
                5'd16: r = 5'd16;
                5'd17: r = 5'd17;
                5'd19: r = 5'd18;
                5'd20: r = 5'd19;
                5'd21: r = 5'd20;
                5'd22: r = 5'd21;
                5'd23: r = 5'd22;
                5'd25: r = 5'd23;
                5'd26: r = 5'd24;
                5'd27: r = 5'd25;
                5'd28: r = 5'd26;
                5'd29: r = 5'd27;
                default: r = 5'd0;
            endcase
        end
        return r;
    endfunction

    // parts of a compound jamo
    function automatic pair_t split_pair(input logic [15:0] c);
        pair_t r;
        r = '{hit: 1'b1, first: 16'h0, second: 16'h0};
        case (c)
            16'h3158: begin r.first = 16'h3157; r.second = 16'h314F; end
            16'h3159: begin r.first = 16'h3157; r.second = 16'h3150; end
            16'h315A: begin r.first = 16'h3157; r.second = 16'h3163; end
            16'h315D: begin r.first = 16'h315C; r.second = 16'h3153; end
            16'h315E: begin r.first = 16'h315C; r.second = 16'h3154; end
            16'h315F: begin r.first = 16'h315C; r.second = 16'h3163; end
            16'h3162: begin r.first = 16'h3161; r.second = 16'h3163; end
            16'h3133: begin r.first = 16'h3131; r.second = 16'h3145; end
            16'h3135: begin r.first = 16'h3134; r.second = 16'h3148; end
            16'h3136: begin r.first = 16'h3134; r.second = 16'h314E; end
            16'h313A: begin r.first = 16'h3139; r.second = 16'h3131; end
            16'h313B: begin r.first = 16'h3139; r.second = 16'h3141; end
            16'h313C: begin r.first = 16'h3139; r.second = 16'h3142; end
            16'h313D: begin r.first = 16'h3139; r.second = 16'h3145; end
            16'h313E: begin r.first = 16'h3139; r.second = 16'h314C; end
            16'h313F: begin r.first = 16'h3139; r.second = 16'h314D; end
            16'h3140: begin r.first = 16'h3139; r.second = 16'h314E; end
            16'h3144: begin r.first = 16'h3142; r.second = 16'h3145; end
            default:  r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // compound formed by two jamo, 0 when they do not combine
    function automatic logic [15:0] join_pair(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] r;
        case ({a, b})
            {16'h3157, 16'h314F}: r = 16'h3158;
            {16'h3157, 16'h3150}: r = 16'h3159;
            {16'h3157, 16'h3163}: r = 16'h315A;
            {16'h315C, 16'h3153}: r = 16'h315D;
            {16'h315C, 16'h3154}: r = 16'h315E;
            {16'h315C, 16'h3163}: r = 16'h315F;
            {16'h3161, 16'h3163}: r = 16'h3162;
            {16'h3131, 16'h3145}: r = 16'h3133;
            {16'h3134, 16'h3148}: r = 16'h3135;
            {16'h3134, 16'h314E}: r = 16'h3136;
            {16'h3139, 16'h3131}: r = 16'h313A;
            {16'h3139, 16'h3141}: r = 16'h313B;
            {16'h3139, 16'h3142}: r = 16'h313C;
            {16'h3139, 16'h3145}: r = 16'h313D;
            {16'h3139, 16'h314C}: r = 16'h313E;
            {16'h3139, 16'h314D}: r = 16'h313F;
            {16'h3139, 16'h314E}: r = 16'h3140;
            {16'h3142, 16'h3145}: r = 16'h3144;
            default:              r = 16'h0;
        endcase
        return r;
    endfunction

    // precomposed syllable from three jamo
    function automatic logic [15:0] syllable(input logic [15:0] ini,
                                             input logic [15:0] med,
                                             input logic [15:0] fin);
        logic [15:0] i;
        logic [15:0] m;
        logic [15:0] f;
        i = {11'd0, init_idx(ini)};
        m = is_vowel(med) ? (med - VOW_FIRST) : 16'd0;
        f = {11'd0, fin_idx(fin)};
        return SYL_BASE + i * INI_STEP + m * MED_STEP + f;
    endfunction

    // character shown for the slots up to the cursor
    function automatic logic [15:0] current_char(input logic [15:0] s0,
                                                 input logic [15:0] s1,
                                                 input logic [15:0] s2,
                                                 input logic [1:0]  cur);
        logic [15:0] r;
        case (cur)
            CUR_INI: r = s0;
            CUR_MED: r = syllable(s0, s1, 16'h0);
            CUR_FIN: r = syllable(s0, s1, s2);
            default: r = 16'h0;
        endcase
        return r;
    endfunction

endpackage

[rtl/hsc_in_reg.sv]
// ----------------------------------------------------------------------------
// hsc_in_reg
// Input register: holds one accepted beat until the compose step takes it.
// ----------------------------------------------------------------------------
module hsc_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // key_code
    input  logic [1:0]         s_axis_tuser,   // cmd
    input  logic               take,
    output logic               item_valid,
    output hsc_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    hsc_pkg::item_t item_reg;

    // free when empty or when the held beat leaves this cycle
    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.cmd      <= s_axis_tuser;
            item_reg.key_code <= s_axis_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/hsc_core.sv]
// ----------------------------------------------------------------------------
// hsc_core
// Jamo slots and cursor with the one-step compose logic for a beat.
// ----------------------------------------------------------------------------
module hsc_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  hsc_pkg::item_t     item,
    output hsc_pkg::result_t   result
);

    logic [15:0] slot_reg [3];
    logic [15:0] slot_next [3];
    logic [1:0]  cursor_reg;
    logic [1:0]  cursor_next;

    logic [15:0]     c_slot [3];
    logic [1:0]      c_cur;
    logic [15:0]     key;
    logic [15:0]     last;
    logic [15:0]     open_char;
    logic [15:0]     joined;
    hsc_pkg::pair_t  pr;
    logic [15:0]     commit;
    logic [15:0]     pass;
    logic            pass_on;
    logic            erase;

    // compose step
    always_comb
    begin
        key    = item.key_code;
        c_slot = slot_reg;
        c_cur  = cursor_reg;
        if (cursor_reg > hsc_pkg::CUR_FIN)
        begin
            c_slot = '{default: 16'h0};
            c_cur  = hsc_pkg::CUR_INI;
        end

        case (c_cur)
            hsc_pkg::CUR_INI: last = c_slot[0];
            hsc_pkg::CUR_MED: last = c_slot[1];
            default:          last = c_slot[2];
        endcase

        open_char = hsc_pkg::current_char(c_slot[0], c_slot[1], c_slot[2], c_cur);
        joined    = hsc_pkg::join_pair(last, key);
        pr        = hsc_pkg::split_pair(last);

        slot_next   = c_slot;
        cursor_next = c_cur;
        commit      = 16'h0;
        pass        = 16'h0;
        pass_on     = 1'b0;
        erase       = 1'b0;

        case (item.cmd)
            hsc_pkg::CMD_KEY:
            begin
                if (!(hsc_pkg::is_cons(key) || hsc_pkg::is_vowel(key)))
                begin
                    // non-jamo key flushes and passes through
                    commit      = open_char;
                    slot_next   = '{default: 16'h0};
                    cursor_next = hsc_pkg::CUR_INI;
                    pass        = key;
                    pass_on     = 1'b1;
                end
                else if (last == 16'h0)
                begin
                    slot_next[c_cur] = key;
                end
                else if (hsc_pkg::is_vowel(key))
                begin
                    if (hsc_pkg::is_vowel(last))
                    begin
                        // compound vowel or new syllable
                        if (joined != 16'h0)
                        begin
                            slot_next[c_cur] = joined;
                        end
                        else
                        begin
                            commit      = open_char;
                            slot_next   = '{key, 16'h0, 16'h0};
                            cursor_next = hsc_pkg::CUR_INI;
                        end
                    end
                    else if (c_cur == hsc_pkg::CUR_INI)
                    begin
                        // lone consonant takes the vowel, compounds split
                        if (pr.hit)
                        begin
                            commit       = pr.first;
                            slot_next[0] = pr.second;
                        end
                        slot_next[1] = key;
                        cursor_next  = hsc_pkg::CUR_MED;
                    end
                    else if (c_cur == hsc_pkg::CUR_FIN)
                    begin
                        // final moves to the next syllable
                        if (pr.hit)
                        begin
                            commit       = hsc_pkg::syllable(c_slot[0], c_slot[1], pr.first);
                            slot_next[0] = pr.second;
                        end
                        else
                        begin
                            commit       = hsc_pkg::syllable(c_slot[0], c_slot[1], 16'h0);
                            slot_next[0] = last;
                        end
                        slot_next[1] = key;
                        slot_next[2] = 16'h0;
                        cursor_next  = hsc_pkg::CUR_MED;
                    end
                end
                else if (hsc_pkg::is_cons(last))
                begin
                    // compound consonant or new syllable
                    if (joined != 16'h0)
                    begin
                        slot_next[c_cur] = joined;
                    end
                    else
                    begin
                        commit      = open_char;
                        slot_next   = '{key, 16'h0, 16'h0};
                        cursor_next = hsc_pkg::CUR_INI;
                    end
                end
                else if (c_cur == hsc_pkg::CUR_MED && hsc_pkg::fin_idx(key) != 5'd0)
                begin
                    slot_next[2] = key;
                    cursor_next  = hsc_pkg::CUR_FIN;
                end
                else
                begin
                    commit      = open_char;
                    slot_next   = '{key, 16'h0, 16'h0};
                    cursor_next = hsc_pkg::CUR_INI;
                end
            end
            hsc_pkg::CMD_BACK:
            begin
                if (last == 16'h0)
                begin
                    erase = 1'b1;
                end
                else if (pr.hit)
                begin
                    slot_next[c_cur] = pr.first;
                end
                else
                begin
                    slot_next[c_cur] = 16'h0;
                    if (c_cur != hsc_pkg::CUR_INI)
                    begin
                        cursor_next = c_cur - 2'd1;
                    end
                end
            end
            hsc_pkg::CMD_FINISH:
            begin
                commit      = open_char;
                slot_next   = '{default: 16'h0};
                cursor_next = hsc_pkg::CUR_INI;
            end
            default:
            begin
                commit = 16'h0;
            end
        endcase

        result.commit_valid    = (commit != 16'h0);
        result.commit_char     = commit;
        result.pass_valid      = pass_on;
        result.pass_char       = pass;
        result.erase_committed = erase;
        result.preedit_char    = hsc_pkg::current_char(slot_next[0], slot_next[1],
                                                       slot_next[2], cursor_next);
    end

    // slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '{default: 16'h0};
            cursor_reg <= hsc_pkg::CUR_INI;
        end
        else if (step_en)
        begin
            slot_reg   <= slot_next;
            cursor_reg <= cursor_next;
        end
    end

endmodule

[rtl/hsc_out_reg.sv]
// ----------------------------------------------------------------------------
// hsc_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module hsc_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  hsc_pkg::result_t   result,
    output logic               space,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [47:0]        m_axis_tdata,   // commit_char, pass_char, preedit_char
    output logic [2:0]         m_axis_tuser    // commit_valid, pass_valid, erase_committed
);

    logic             valid_reg;
    logic             valid_next;
    hsc_pkg::result_t res_reg;

    // room when empty or when the held beat is taken this cycle
    assign space = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
        begin
            valid_next = load;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {res_reg.preedit_char, res_reg.pass_char, res_reg.commit_char};
    assign m_axis_tuser  = {res_reg.erase_committed, res_reg.pass_valid, res_reg.commit_valid};

endmodule

[rtl/hangul_syllable_composer.sv]
// ----------------------------------------------------------------------------
// hangul_syllable_composer
// Composes two-set Korean jamo keystrokes into precomposed syllables. Each
// input beat carries a command (key, backspace, finish) and a key code; each
// beat yields exactly one result beat with the committed character, a
// passed-through non-jamo key, an erase request and the current preedit
// syllable. The block takes one beat per clock while the sink keeps up; an
// accepted beat is registered in the input register, and the single compose
// step (table lookups and constant multiplies on the jamo slots) writes the
// slot state and the result register as the beat leaves the input register.
// A stalled sink holds the result register, and one more beat then waits in
// the input register before the input side stalls.
// ----------------------------------------------------------------------------
module hangul_syllable_composer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // key_code
    input  logic [1:0]   s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // commit_char, pass_char, preedit_char
    output logic [2:0]   m_axis_tuser    // commit_valid, pass_valid, erase_committed
);

`include "hangul_syllable_composer_assert.svh"

    logic               item_valid;
    hsc_pkg::item_t     item;
    hsc_pkg::result_t   result;
    logic               space;
    logic               fire;

    // a beat moves through the compose step when the result register has room
    assign fire = item_valid && space;

    hsc_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (fire),
        .item_valid    (item_valid),
        .item          (item)
    );

    hsc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .item    (item),
        .result  (result)
    );

    hsc_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .result        (result),
        .space         (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // checks
    `HSC_ASSERT_NEXT(a_fire_gives_result, fire, m_axis_tvalid, "composed beat did not reach output")
    `HSC_ASSERT_NEXT(a_item_held, item_valid && !fire, item_valid, "waiting beat was dropped")
    `HSC_ASSERT_NOW(a_erase_alone, m_axis_tvalid && m_axis_tuser[2], !m_axis_tuser[0] && !m_axis_tuser[1] && m_axis_tdata[47:32] == 16'h0, "erase beat carries other output")
    `HSC_ASSERT_NOW(a_pass_clears, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[47:32] == 16'h0, "preedit not empty after pass-through")

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hangul syllable composer testbench
// Drives key, backspace, finish and unused-command beats into the composer,
// predicts each result beat from its own copy of the jamo slots and cursor,
// and compares every returned beat field by field. A short directed part
// covers the edge keys and compound rules, then random typing of well-formed
// syllables and random noise run with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    // command value that the block ignores
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    // marks a consonant that cannot start a syllable
    localparam logic [4:0] NO_INITIAL  = 5'h1F;
    localparam int         COMPOUNDS   = 18;
    localparam int         VOWEL_PAIRS = 7;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = 16'h0;            // key_code
    logic [1:0]   s_axis_tuser = hsc_pkg::CMD_KEY; // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;           // commit_char, pass_char, preedit_char
    logic [2:0]   m_axis_tuser;           // commit_valid, pass_valid, erase_committed

    // predicted composer state
    logic [15:0]  slot_jamo [0:2];
    logic [1:0]   slot_pos;

    hsc_pkg::result_t expected_keystroke_results [$];
    int           beats_sent = 0;
    int           beats_seen = 0;
    int           commits_seen = 0;
    int           passes_seen = 0;
    int           erases_seen = 0;
    int           mismatch_count = 0;
    bit           send_gaps = 1'b1;
    bit           sink_stalls = 1'b1;
    int           stall_left = 0;

    hangul_syllable_composer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // jamo tables and composition predictor
    // ------------------------------------------------------------------------

    function automatic bit jamo_cons(input logic [15:0] c);
        return (c >= hsc_pkg::CONS_FIRST) && (c <= hsc_pkg::CONS_LAST);
    endfunction

    function automatic bit jamo_vowel(input logic [15:0] c);
        return (c >= hsc_pkg::VOW_FIRST) && (c <= hsc_pkg::VOW_LAST);
    endfunction

    // initial index by offset from the first consonant
    function automatic logic [4:0] initial_index(input logic [15:0] c);
        int off;
        off = int'(c) - int'(hsc_pkg::CONS_FIRST);
        case (off)
            0:       return 5'd0;
            1:       return 5'd1;
            3:       return 5'd2;
            6:       return 5'd3;
            7:       return 5'd4;
            8:       return 5'd5;
            16:      return 5'd6;
            17:      return 5'd7;
            18:      return 5'd8;
            default:
            begin
                if (off >= 20 && off <= 29)
                    return 5'(off - 11);
                return NO_INITIAL;
            end
        endcase
    endfunction

    // final index by offset, 0 for consonants that cannot close a syllable
    function automatic logic [4:0] final_index(input logic [15:0] c);
        int off;
        off = int'(c) - int'(hsc_pkg::CONS_FIRST);
        if (off >= 0 && off <= 6)
            return 5'(off + 1);
        if (off >= 8 && off <= 17)
            return 5'(off);
        if (off >= 19 && off <= 23)
            return 5'(off - 1);
        if (off >= 25 && off <= 29)
            return 5'(off - 2);
        return 5'd0;
    endfunction

    // compound jamo k as {whole, first part, second part}; vowels come first
    function automatic logic [47:0] compound_entry(input int k);
        case (k)
            0:       return {16'h3158, 16'h3157, 16'h314F};
            1:       return {16'h3159, 16'h3157, 16'h3150};
            2:       return {16'h315A, 16'h3157, 16'h3163};
            3:       return {16'h315D, 16'h315C, 16'h3153};
            4:       return {16'h315E, 16'h315C, 16'h3154};
            5:       return {16'h315F, 16'h315C, 16'h3163};
            6:       return {16'h3162, 16'h3161, 16'h3163};
            7:       return {16'h3133, 16'h3131, 16'h3145};
            8:       return {16'h3135, 16'h3134, 16'h3148};
            9:       return {16'h3136, 16'h3134, 16'h314E};
            10:      return {16'h313A, 16'h3139, 16'h3131};
            11:      return {16'h313B, 16'h3139, 16'h3141};
            12:      return {16'h313C, 16'h3139, 16'h3142};
            13:      return {16'h313D, 16'h3139, 16'h3145};
            14:      return {16'h313E, 16'h3139, 16'h314C};
            15:      return {16'h313F, 16'h3139, 16'h314D};
            16:      return {16'h3140, 16'h3139, 16'h314E};
            default: return {16'h3144, 16'h3142, 16'h3145};
        endcase
    endfunction

    function automatic int compound_find(input logic [15:0] c);
        logic [47:0] e;
        for (int k = 0; k < COMPOUNDS; k++)
        begin
            e = compound_entry(k);
            if (e[47:32] == c)
                return k;
        end
        return -1;
    endfunction

    function automatic logic [15:0] compound_join(input logic [15:0] a, input logic [15:0] b);
        logic [47:0] e;
        for (int k = 0; k < COMPOUNDS; k++)
        begin
            e = compound_entry(k);
            if (e[31:16] == a && e[15:0] == b)
                return e[47:32];
        end
        return 16'h0;
    endfunction

    function automatic logic [15:0] syllable_code(input logic [15:0] ini,
                                                  input logic [15:0] med,
                                                  input logic [15:0] fin);
        int i;
        int m;
        int f;
        i = 0;
        m = 0;
        f = 0;
        if (jamo_cons(ini) && initial_index(ini) != NO_INITIAL)
            i = int'(initial_index(ini));
        if (jamo_vowel(med))
            m = int'(med) - int'(hsc_pkg::VOW_FIRST);
        if (jamo_cons(fin))
            f = int'(final_index(fin));
        return 16'(int'(hsc_pkg::SYL_BASE) + i * 588 + m * 28 + f);
    endfunction

    // character shown for the predicted slots
    function automatic logic [15:0] shown_char();
        case (slot_pos)
            hsc_pkg::CUR_INI: return slot_jamo[0];
            hsc_pkg::CUR_MED: return syllable_code(slot_jamo[0], slot_jamo[1], 16'h0);
            hsc_pkg::CUR_FIN: return syllable_code(slot_jamo[0], slot_jamo[1], slot_jamo[2]);
            default:          return 16'h0;
        endcase
    endfunction

    function automatic void empty_buffer();
        slot_jamo[0] = 16'h0;
        slot_jamo[1] = 16'h0;
        slot_jamo[2] = 16'h0;
        slot_pos = hsc_pkg::CUR_INI;
    endfunction

    // commit the open syllable and start a new one with key
    function automatic logic [15:0] start_over(input logic [15:0] key);
        logic [15:0] r;
        r = shown_char();
        empty_buffer();
        slot_jamo[0] = key;
        return r;
    endfunction

    // add one jamo to the buffer, returns the committed code point or 0
    function automatic logic [15:0] add_jamo(input logic [15:0] key);
        logic [15:0] last;
        logic [15:0] merged;
        logic [15:0] r;
        logic [47:0] e;
        int          k;
        last = slot_jamo[slot_pos];
        if (last == 16'h0)
        begin
            slot_jamo[slot_pos] = key;
            return 16'h0;
        end
        if (jamo_vowel(key))
        begin
            if (jamo_vowel(last))
            begin
                merged = compound_join(last, key);
                if (merged != 16'h0)
                begin
                    slot_jamo[slot_pos] = merged;
                    return 16'h0;
                end
                return start_over(key);
            end
            // lone consonant, a compound gives up its second part
            if (slot_pos == hsc_pkg::CUR_INI)
            begin
                k = compound_find(last);
                r = 16'h0;
                if (k >= 0)
                begin
                    e = compound_entry(k);
                    r = e[31:16];
                    slot_jamo[0] = e[15:0];
                end
                slot_jamo[1] = key;
                slot_pos = hsc_pkg::CUR_MED;
                return r;
            end
            // final consonant moves over to the next syllable
            if (slot_pos == hsc_pkg::CUR_FIN)
            begin
                k = compound_find(last);
                if (k >= 0)
                begin
                    e = compound_entry(k);
                    r = syllable_code(slot_jamo[0], slot_jamo[1], e[31:16]);
                    slot_jamo[0] = e[15:0];
                end
                else
                begin
                    r = syllable_code(slot_jamo[0], slot_jamo[1], 16'h0);
                    slot_jamo[0] = last;
                end
                slot_jamo[1] = key;
                slot_jamo[2] = 16'h0;
                slot_pos = hsc_pkg::CUR_MED;
                return r;
            end
            return 16'h0;
        end
        if (jamo_cons(last))
        begin
            merged = compound_join(last, key);
            if (merged != 16'h0)
            begin
                slot_jamo[slot_pos] = merged;
                return 16'h0;
            end
            return start_over(key);
        end
        if (slot_pos == hsc_pkg::CUR_MED && final_index(key) != 5'd0)
        begin
            slot_jamo[2] = key;
            slot_pos = hsc_pkg::CUR_FIN;
            return 16'h0;
        end
        return start_over(key);
    endfunction

    // expected result beat for one accepted command beat
    function automatic hsc_pkg::result_t compose_keystroke(input logic [1:0] cmd,
                                                           input logic [15:0] key);
        hsc_pkg::result_t res;
        logic [15:0] commit;
        logic [15:0] pass;
        logic [15:0] last;
        logic [47:0] e;
        logic        pass_on;
        logic        erase;
        int          k;
        commit = 16'h0;
        pass = 16'h0;
        pass_on = 1'b0;
        erase = 1'b0;
        if (slot_pos > hsc_pkg::CUR_FIN)
            empty_buffer();
        case (cmd)
            hsc_pkg::CMD_KEY:
            begin
                if (jamo_cons(key) || jamo_vowel(key))
                    commit = add_jamo(key);
                else
                begin
                    commit = shown_char();
                    empty_buffer();
                    pass = key;
                    pass_on = 1'b1;
                end
            end
            hsc_pkg::CMD_BACK:
            begin
                last = slot_jamo[slot_pos];
                if (last == 16'h0)
                    erase = 1'b1;
                else
                begin
                    k = compound_find(last);
                    if (k >= 0)
                    begin
                        e = compound_entry(k);
                        slot_jamo[slot_pos] = e[31:16];
                    end
                    else
                    begin
                        slot_jamo[slot_pos] = 16'h0;
                        if (slot_pos > hsc_pkg::CUR_INI)
                            slot_pos = slot_pos - 2'd1;
                    end
                end
            end
            hsc_pkg::CMD_FINISH:
            begin
                commit = shown_char();
                empty_buffer();
            end
            default:
            begin
            end
        endcase
        res.commit_valid = (commit != 16'h0);
        res.commit_char = commit;
        res.pass_valid = pass_on;
        res.pass_char = pass;
        res.erase_committed = erase;
        res.preedit_char = shown_char();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stream drivers
    // ------------------------------------------------------------------------

    // idle length for either side: mostly none, some short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // send one command beat and record its expected result on acceptance
    task automatic send_beat(input logic [1:0] cmd, input logic [15:0] key);
        int gap;
        bit ready_seen;
        gap = send_gaps ? idle_length() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= key;
        s_axis_tuser <= cmd;
        // inputs are stable at the falling edge, so tready there holds at the next rise
        do
        begin
            @(negedge clk);
            ready_seen = s_axis_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        expected_keystroke_results.push_back(compose_keystroke(cmd, key));
        beats_sent++;
    endtask

    // result sink with random stall stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rst_n && sink_stalls && idle_length() > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= idle_length();
        end
        else
            m_axis_tready <= rst_n;
    end

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string detail);
        $display("ERROR beat %0d: %s", beats_seen, detail);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", field, got, want));
    endtask

    // a beat seen at the falling edge with valid and ready is taken at the next rise
    always @(negedge clk)
    begin
        hsc_pkg::result_t got;
        hsc_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.commit_valid = m_axis_tuser[0];
            got.pass_valid = m_axis_tuser[1];
            got.erase_committed = m_axis_tuser[2];
            got.commit_char = m_axis_tdata[15:0];
            got.pass_char = m_axis_tdata[31:16];
            got.preedit_char = m_axis_tdata[47:32];
            if (expected_keystroke_results.size() == 0)
                report_mismatch($sformatf("result beat with none expected, data %h user %b",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                want = expected_keystroke_results.pop_front();
                check_field("commit_valid", 16'(got.commit_valid), 16'(want.commit_valid));
                check_field("commit_char", got.commit_char, want.commit_char);
                check_field("pass_valid", 16'(got.pass_valid), 16'(want.pass_valid));
                check_field("pass_char", got.pass_char, want.pass_char);
                check_field("erase_committed", 16'(got.erase_committed),
                            16'(want.erase_committed));
                check_field("preedit_char", got.preedit_char, want.preedit_char);
            end
            beats_seen++;
            commits_seen += got.commit_valid;
            passes_seen += got.pass_valid;
            erases_seen += got.erase_committed;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty-buffer commands, range edges and the unused command
    task automatic test_edge_keys();
        send_beat(hsc_pkg::CMD_BACK, 16'h0000);
        send_beat(hsc_pkg::CMD_FINISH, 16'hFFFF);
        send_beat(hsc_pkg::CMD_KEY, 16'h0000);
        send_beat(hsc_pkg::CMD_KEY, 16'hFFFF);
        send_beat(CMD_UNUSED, 16'h3131);
        send_beat(hsc_pkg::CMD_KEY, 16'h3130);
        send_beat(hsc_pkg::CMD_KEY, hsc_pkg::CONS_FIRST);
        send_beat(hsc_pkg::CMD_KEY, hsc_pkg::VOW_LAST);
        send_beat(CMD_UNUSED, 16'h5A5A);
        send_beat(hsc_pkg::CMD_KEY, hsc_pkg::CONS_LAST);
        send_beat(hsc_pkg::CMD_KEY, 16'h3164);
        send_beat(hsc_pkg::CMD_BACK, 16'h0000);
    endtask

    // compound vowels and finals, their backspace and split rules
    task automatic test_compound_rules();
        send_beat(hsc_pkg::CMD_KEY, 16'h3147);
        send_beat(hsc_pkg::CMD_KEY, 16'h3157);
        send_beat(hsc_pkg::CMD_KEY, hsc_pkg::VOW_FIRST);
        send_beat(hsc_pkg::CMD_BACK, 16'h0000);
        send_beat(hsc_pkg::CMD_KEY, 16'h3139);
        send_beat(hsc_pkg::CMD_KEY, 16'h314E);
        send_beat(hsc_pkg::CMD_BACK, 16'h0000);
        send_beat(hsc_pkg::CMD_KEY, 16'h314E);
        send_beat(hsc_pkg::CMD_KEY, hsc_pkg::VOW_FIRST);
        // double consonant cannot close the open syllable
        send_beat(hsc_pkg::CMD_KEY, 16'h3138);
        send_beat(hsc_pkg::CMD_KEY, 16'h313C);
        send_beat(hsc_pkg::CMD_KEY, 16'h3153);
        send_beat(hsc_pkg::CMD_FINISH, 16'h0000);
    endtask

    // one syllable with random content, often with compound parts
    task automatic type_syllable();
        logic [47:0] e;
        send_beat(hsc_pkg::CMD_KEY, 16'(hsc_pkg::CONS_FIRST + $urandom_range(0, 29)));
        if ($urandom_range(0, 3) == 0)
        begin
            e = compound_entry($urandom_range(0, VOWEL_PAIRS - 1));
            send_beat(hsc_pkg::CMD_KEY, e[31:16]);
            send_beat(hsc_pkg::CMD_KEY, e[15:0]);
        end
        else
            send_beat(hsc_pkg::CMD_KEY, 16'(hsc_pkg::VOW_FIRST + $urandom_range(0, 20)));
        if ($urandom_range(0, 9) < 6)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                e = compound_entry($urandom_range(VOWEL_PAIRS, COMPOUNDS - 1));
                send_beat(hsc_pkg::CMD_KEY, e[31:16]);
                send_beat(hsc_pkg::CMD_KEY, e[15:0]);
            end
            else
                send_beat(hsc_pkg::CMD_KEY, 16'(hsc_pkg::CONS_FIRST + $urandom_range(0, 29)));
        end
    endtask

    function automatic int urandom16();
        return $urandom_range(0, 65535);
    endfunction

    // mostly well-formed text with edits, idling switched per stretch
    task automatic test_random_typing(input int count);
        int target;
        int r;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 199) == 0)
            begin
                send_gaps = $urandom_range(0, 1);
                sink_stalls = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                type_syllable();
            else if (r < 78)
                repeat ($urandom_range(1, 3)) send_beat(hsc_pkg::CMD_BACK, 16'(urandom16()));
            else if (r < 84)
                send_beat(hsc_pkg::CMD_FINISH, 16'(urandom16()));
            else if (r < 92)
                send_beat(hsc_pkg::CMD_KEY,
                          ($urandom_range(0, 1) == 0) ? 16'h0020 : 16'(urandom16()));
            else
                send_beat(hsc_pkg::CMD_KEY, 16'(hsc_pkg::CONS_FIRST + $urandom_range(0, 50)));
        end
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // any command with keys near the jamo range or anywhere
    task automatic test_random_noise(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 1) == 0)
                send_beat(2'($urandom_range(0, 3)), 16'(urandom16()));
            else
                send_beat(2'($urandom_range(0, 3)), 16'(16'h3130 + $urandom_range(0, 16'h34)));
        end
    endtask

    initial
    begin
        empty_buffer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_keys();
        test_compound_rules();
        test_random_typing(1500);
        test_random_noise(500);

        s_axis_tvalid <= 1'b0;
        while (expected_keystroke_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d command beats and %0d result beats", beats_sent, beats_seen);
        $display("results held %0d commits, %0d pass-through keys, %0d erase requests",
                 commits_seen, passes_seen, erases_seen);
        if (mismatch_count == 0)
            $display("hangul_syllable_composer verification clean");
        else
            $display("hangul_syllable_composer verification failed");
        $finish;
    end

    // run limit well above the slowest correct run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d result beats outstanding", expected_keystroke_results.size());
        $display("hangul_syllable_composer verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/hsc_pkg.sv
rtl/hsc_in_reg.sv
rtl/hsc_core.sv
rtl/hsc_out_reg.sv
rtl/hangul_syllable_composer.sv
dv/testbench.sv
